/* hdl/dpd_pkg.sv */
// Shared types, character codes and the hex digit decoder for the debug packet deframer.
`timescale 1ns / 1ps

package dpd_pkg;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;
    localparam logic [7:0] CH_INTR  = 8'h03;

    typedef enum logic [2:0] {
        EV_PAYLOAD = 3'd0,
        EV_GOOD    = 3'd1,
        EV_BAD     = 3'd2,
        EV_INTR    = 3'd3,
        EV_RESTART = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [7:0]  payload;
        logic [7:0]  ack;
    } dpd_event_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

/* hdl/dpd_core.sv */
// Packet framing state machine: phase, running checksum and result decode for one byte.
`timescale 1ns / 1ps

module dpd_core
    import dpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       chunk_end,
    output dpd_event_t ev
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_BODY  = 2'd1,
        PH_CSUM1 = 2'd2,
        PH_CSUM2 = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [3:0] chigh_reg, chigh_next;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        chigh_next = chigh_reg;
        ev         = '{valid: 1'b0, kind: EV_PAYLOAD, payload: 8'd0, ack: 8'd0};
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == CH_START)
                begin
                    phase_next = PH_BODY;
                    sum_next   = 8'd0;
                end
                else if (rx_byte == CH_INTR)
                begin
                    ev.valid = 1'b1;
                    ev.kind  = EV_INTR;
                end
            end
            PH_BODY:
            begin
                if (rx_byte == CH_START)
                begin
                    sum_next = 8'd0;
                    ev.valid = 1'b1;
                    ev.kind  = EV_RESTART;
                end
                else if (rx_byte == CH_HASH)
                begin
                    phase_next = PH_CSUM1;
                end
                else
                begin
                    sum_next   = sum_reg + rx_byte;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_PAYLOAD;
                    ev.payload = rx_byte;
                end
            end
            PH_CSUM1:
            begin
                chigh_next = hex_value(rx_byte);
                phase_next = PH_CSUM2;
            end
            PH_CSUM2:
            begin
                ev.valid   = 1'b1;
                phase_next = PH_HUNT;
                if ({chigh_reg, hex_value(rx_byte)} == sum_reg)
                begin
                    ev.kind = EV_GOOD;
                    ev.ack  = CH_ACK;
                end
                else
                begin
                    ev.kind = EV_BAD;
                    ev.ack  = CH_NAK;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
        // drop any partial packet at the end of a chunk
        if (chunk_end && phase_next != PH_HUNT)
        begin
            phase_next = PH_HUNT;
            sum_next   = 8'd0;
            chigh_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            chigh_reg <= 4'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            chigh_reg <= chigh_next;
        end
    end

endmodule

/* hdl/debug_packet_deframer.sv */
// A byte passes through the input stage register and then the result register before its result is offered.
// Throughput: one byte per cycle while m_tready does not stall the output; the framing state update is a single pass.
// Input stage and result register each hold one transfer; both stall on m_tready.
// Reset (rst_n low, asynchronous) empties both stages and returns to hunting
// with the running sum and checksum digit cleared.
`timescale 1ns / 1ps

module debug_packet_deframer
    import dpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [15:8] ack_char
    output logic [2:0]  m_tuser    // [2:0] event_kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    event_kind_t out_kind_reg;
    logic [7:0]  out_payload_reg;
    logic [7:0]  out_ack_reg;
    logic        advance;
    logic        step;
    dpd_event_t  ev;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    dpd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .chunk_end (in_last_reg),
        .ev        (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= step && ev.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && ev.valid)
        begin
            out_kind_reg    <= ev.kind;
            out_payload_reg <= ev.payload;
            out_ack_reg     <= ev.ack;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_ack_reg, out_payload_reg};

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !s_tready)
        else $error("input stage overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("pending result changed before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != EV_PAYLOAD) |-> (m_tdata[7:0] == 8'd0))
        else $error("payload byte set on a non-payload result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_GOOD || m_tuser == EV_BAD))
            |-> (m_tdata[15:8] == CH_ACK || m_tdata[15:8] == CH_NAK))
        else $error("end result without acknowledge character");
`endif

endmodule
